// File: rtl/txfp_pkg.sv
// shared types and constants for the transmit frame word packer
package txfp_pkg;

	// frame length rules
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] MIN_FRAME_BYTES = 6'd60;
	localparam logic [CNT_W-1:0] WORD_BYTES = 6'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EOF_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_MARKER = 1'b1;

	// datapath operations issued by the controller
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
	localparam logic [OP_W-1:0] OP_HOLD       = 3'd1;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd2;
	localparam logic [OP_W-1:0] OP_FINAL_BYTE = 3'd3;
	localparam logic [OP_W-1:0] OP_ZERO       = 3'd4;
	localparam logic [OP_W-1:0] OP_FINAL_PAD  = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;     // output register empty or emptied this cycle
		logic count_short;  // byte count including the incoming item is below minimum
		logic total_short;  // padded total is still below minimum
		logic lane_wrap;    // incoming item completes a word
	} stat_t;

endpackage

// File: rtl/txfp_ctrl.sv
// controller state machine: byte intake and end-of-frame padding sequence
module txfp_ctrl import txfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  frame_end,
	input  stat_t stat,
	output logic  in_stall,
	output cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_PAD  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// take a byte only while idle and the output register can be loaded
	assign in_stall = (state_q != ST_IDLE) || !stat.out_free;
	assign accept   = in_valid && !in_stall;

	// operation select and next state
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!frame_end) begin
						cmd.op = OP_HOLD;
					end else if (stat.count_short) begin
						cmd.op  = OP_FLUSH;
						state_d = ST_PAD;
					end else begin
						// long frame: the final word closes here, or follows a full word if this byte completes one
						cmd.op = OP_FINAL_BYTE;
						if (stat.lane_wrap) begin
							state_d = ST_PAD;
						end
					end
				end
			end
			ST_PAD: begin
				if (stat.out_free) begin
					if (stat.total_short) begin
						cmd.op = OP_ZERO;
					end else begin
						cmd.op  = OP_FINAL_PAD;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/txfp_dp.sv
// datapath: lane packing, byte count, marker registers and output register
module txfp_dp import txfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [7:0]           data_byte,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [31:0]          fifo_word,
	output logic [3:0]           control_lanes,
	output logic                 last_word
);

	logic [1:0]       lane_q;
	logic [23:0]      part_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       eof_q;
	logic [7:0]       pad_q;
	logic             out_valid_q;
	logic [31:0]      word_q;
	logic [3:0]       mask_q;
	logic             last_q;

	logic [31:0]      merged;
	logic [1:0]       lane_nx;
	logic             wrap;
	logic [CNT_W-1:0] cnt_nx;
	logic [CNT_W-1:0] cnt_rnd;
	logic             load;
	logic [31:0]      load_word;
	logic [3:0]       load_mask;
	logic             load_last;

	// end marker at the given lane, pad markers above it
	function automatic logic [31:0] close_word(input logic [31:0] w, input logic [1:0] lane,
			input logic [7:0] eof, input logic [7:0] pad);
		logic [31:0] r;
		r = w;
		for (int l = 0; l < 4; l++) begin
			if (l[1:0] == lane) begin
				r[l*8 +: 8] = eof;
			end else if (l[1:0] > lane) begin
				r[l*8 +: 8] = pad;
			end
		end
		return r;
	endfunction

	// incoming byte placed into its lane
	assign merged  = {8'h00, part_q} | ({24'h000000, data_byte} << {lane_q, 3'b000});
	assign lane_nx = lane_q + 2'd1;
	assign wrap    = (lane_nx == 2'd0);
	assign cnt_nx  = (cnt_q < MIN_FRAME_BYTES) ? cnt_q + 6'd1 : cnt_q;
	// short frame total rounded up to a whole word
	assign cnt_rnd = (cnt_nx + 6'd3) & ~6'd3;

	// status to the controller
	assign stat.out_free    = !out_valid_q || !out_stall;
	assign stat.count_short = (cnt_nx < MIN_FRAME_BYTES);
	assign stat.total_short = (cnt_q < MIN_FRAME_BYTES);
	assign stat.lane_wrap   = wrap;

	// output load select
	always_comb begin
		load      = 1'b0;
		load_word = merged;
		load_mask = 4'h0;
		load_last = 1'b0;
		case (cmd.op)
			OP_HOLD: begin
				load = wrap;
			end
			OP_FLUSH: begin
				load = 1'b1;
			end
			OP_FINAL_BYTE: begin
				load = 1'b1;
				if (!wrap) begin
					load_word = close_word(merged, lane_nx, eof_q, pad_q);
					load_mask = 4'hF << lane_nx;
					load_last = 1'b1;
				end
			end
			OP_ZERO: begin
				load      = 1'b1;
				load_word = 32'h0;
			end
			OP_FINAL_PAD: begin
				load      = 1'b1;
				load_word = close_word(32'h0, 2'd0, eof_q, pad_q);
				load_mask = 4'hF;
				load_last = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= 2'd0;
			part_q <= 24'h0;
			cnt_q  <= '0;
		end else begin
			case (cmd.op)
				OP_HOLD: begin
					lane_q <= lane_nx;
					part_q <= wrap ? 24'h0 : merged[23:0];
					cnt_q  <= cnt_nx;
				end
				OP_FLUSH: begin
					lane_q <= 2'd0;
					part_q <= 24'h0;
					cnt_q  <= cnt_rnd;
				end
				OP_FINAL_BYTE: begin
					lane_q <= 2'd0;
					part_q <= 24'h0;
					// after a full word the final word still follows from the pad state
					cnt_q  <= wrap ? cnt_nx : '0;
				end
				OP_ZERO: begin
					cnt_q <= cnt_q + WORD_BYTES;
				end
				OP_FINAL_PAD: begin
					cnt_q <= '0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eof_q <= 8'h00;
			pad_q <= 8'h00;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_EOF_MARKER: eof_q <= cfg_data;
				REG_PAD_MARKER: pad_q <= cfg_data;
				default: begin
					eof_q <= eof_q;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
			mask_q <= load_mask;
			last_q <= load_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign fifo_word     = word_q;
	assign control_lanes = mask_q;
	assign last_word     = last_q;

endmodule

// File: rtl/tx_frame_word_packer_top.sv
// Transmit frame word packer: bytes in, 32-bit FIFO words with control-lane masks out.
// Input channel: data_byte and frame_end, accepted when in_valid is high and in_stall low.
// Output channel: fifo_word, control_lanes, last_word, taken when out_valid is high and
// out_stall low. Bytes pack little-endian; a word of four payload bytes leaves with mask 0.
// Marker registers: cfg_index 0 is the end marker, 1 the pad marker, written on cfg_wr_en.
// A result is loaded into the output register in the cycle after the item that causes it.
// Throughput: one byte per cycle while the output register drains each cycle and no
// end-of-frame sequence runs, and an item waits while the single output register holds a
// stalled result. At the end of a short frame the controller emits the remaining words
// one per cycle while out_stall is low: the flushed last data word, zero words up to the
// minimum frame length and the final word with the end marker; the input stalls meanwhile.
// Reset clears the lane position, partial word, byte count, markers and output valid.
// While out_stall is high with out_valid set, the output word holds and no further item is accepted.
module tx_frame_word_packer_top import txfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          fifo_word,
	output logic [3:0]           control_lanes,
	output logic                 last_word,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// controller
	txfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// datapath
	txfp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.data_byte     (data_byte),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.fifo_word     (fifo_word),
		.control_lanes (control_lanes),
		.last_word     (last_word)
	);

`ifndef SYNTHESIS
	// the final word always carries at least the end marker lane
	a_last_has_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> control_lanes != 4'h0)
		else $error("final word without control lanes");

	// data and padding words carry no control lanes
	a_data_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> control_lanes == 4'h0)
		else $error("control lanes set on a data word");

	// a frame end always produces a result in the next cycle
	a_end_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> out_valid)
		else $error("frame end produced no word");
`endif

endmodule
